// ----- rtl/sbb_pkg.sv -----
package sbb_pkg;

	// Field widths of the item and result channels.
	localparam int POS_W      = 24;
	localparam int BONE_ID_W  = 9;
	localparam int WEIGHT_W   = 8;
	localparam int BONE_IDX_W = 6;
	localparam int CNT_W      = 7;
	localparam int EXT_W      = 23;
	localparam int NUM_INFL   = 4;
	localparam int INFL_W     = 2;

	// Configuration port.
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	// Defaults for the top-level parameters.
	localparam int DEF_MAX_BONES  = 64;
	localparam int DEF_INFLUENCES = 4;

	// Register reset values.
	localparam logic [CNT_W-1:0]    RST_BONE_COUNT = 7'd64;
	localparam logic [WEIGHT_W-1:0] RST_WEIGHT_THR = 8'd102;
	localparam logic [EXT_W-1:0]    RST_MIN_EXTENT = 23'd4;
	localparam logic [EXT_W-1:0]    RST_PADDING    = 23'd41;

	// Saturation limits of the Q11.12 range.
	localparam logic signed [POS_W-1:0] Q_MIN = 24'sh800000;
	localparam logic signed [POS_W-1:0] Q_MAX = 24'sh7FFFFF;

	typedef logic signed [POS_W-1:0] pos_t;

	// Register indexes (byte address divided by four).
	typedef enum logic [1:0] {
		REG_BONE_COUNT,
		REG_WEIGHT_THR,
		REG_MIN_EXTENT,
		REG_PADDING
	} sbb_reg_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_V_RD,
		ST_V_WR,
		ST_F_RD,
		ST_F_EVAL,
		ST_F_DONE
	} sbb_state_t;

	typedef struct packed {
		logic [CNT_W-1:0]    bone_count;
		logic [WEIGHT_W-1:0] weight_threshold;
		logic [EXT_W-1:0]    min_extent;
		logic [EXT_W-1:0]    padding;
	} sbb_cfg_t;

	// One stored bone box.
	typedef struct packed {
		pos_t lo_x;
		pos_t lo_y;
		pos_t lo_z;
		pos_t hi_x;
		pos_t hi_y;
		pos_t hi_z;
	} sbb_box_t;

	// One result item.
	typedef struct packed {
		logic                  box_valid;
		logic [BONE_IDX_W-1:0] bone_index;
		pos_t                  min_x;
		pos_t                  min_y;
		pos_t                  min_z;
		pos_t                  max_x;
		pos_t                  max_y;
		pos_t                  max_z;
		logic                  last;
	} sbb_res_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic in_ready;
		logic load_item;
		logic infl_clr;
		logic infl_inc;
		logic bone_clr;
		logic bone_inc;
		logic rd_vtx;
		logic rd_bone;
		logic wr_vtx;
		logic take_box;
		logic finish;
	} sbb_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic in_valid;
		logic in_flush;
		logic infl_hit;
		logic infl_last;
		logic bone_touched;
		logic bone_last;
		logic kept;
		logic pend_valid;
		logic out_free;
	} sbb_status_t;

	// Saturate a 25-bit sum to the 24-bit range.
	function automatic pos_t sat25(input logic signed [POS_W:0] v);
		pos_t r;
		if (v[POS_W] != v[POS_W-1]) begin
			r = v[POS_W] ? Q_MIN : Q_MAX;
		end else begin
			r = v[POS_W-1:0];
		end
		return r;
	endfunction

endpackage

// ----- rtl/sbb_vtx_if.sv -----
interface sbb_vtx_if import sbb_pkg::*; ();
	logic                        valid;
	logic                        ready;
	logic                        operation;
	logic signed [POS_W-1:0]     pos_x;
	logic signed [POS_W-1:0]     pos_y;
	logic signed [POS_W-1:0]     pos_z;
	logic signed [BONE_ID_W-1:0] bone_a;
	logic signed [BONE_ID_W-1:0] bone_b;
	logic signed [BONE_ID_W-1:0] bone_c;
	logic signed [BONE_ID_W-1:0] bone_d;
	logic [WEIGHT_W-1:0]         weight_a;
	logic [WEIGHT_W-1:0]         weight_b;
	logic [WEIGHT_W-1:0]         weight_c;
	logic [WEIGHT_W-1:0]         weight_d;

	modport source (
		output valid, operation, pos_x, pos_y, pos_z,
		output bone_a, bone_b, bone_c, bone_d,
		output weight_a, weight_b, weight_c, weight_d,
		input ready
	);

	modport sink (
		input valid, operation, pos_x, pos_y, pos_z,
		input bone_a, bone_b, bone_c, bone_d,
		input weight_a, weight_b, weight_c, weight_d,
		output ready
	);
endinterface

// ----- rtl/sbb_box_if.sv -----
interface sbb_box_if import sbb_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    box_valid;
	logic [BONE_IDX_W-1:0]   bone_index;
	logic signed [POS_W-1:0] min_x;
	logic signed [POS_W-1:0] min_y;
	logic signed [POS_W-1:0] min_z;
	logic signed [POS_W-1:0] max_x;
	logic signed [POS_W-1:0] max_y;
	logic signed [POS_W-1:0] max_z;
	logic                    last;

	modport source (
		output valid, box_valid, bone_index, min_x, min_y, min_z,
		output max_x, max_y, max_z, last,
		input ready
	);

	modport sink (
		input valid, box_valid, bone_index, min_x, min_y, min_z,
		input max_x, max_y, max_z, last,
		output ready
	);
endinterface

// ----- rtl/sbb_cfg.sv -----
module sbb_cfg import sbb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output sbb_cfg_t           cfg
);

	sbb_cfg_t cfg_q;
	sbb_reg_t reg_idx;
	logic     wr_en;

	assign reg_idx = sbb_reg_t'(paddr[3:2]);
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	// Register file, written in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bone_count       <= RST_BONE_COUNT;
			cfg_q.weight_threshold <= RST_WEIGHT_THR;
			cfg_q.min_extent       <= RST_MIN_EXTENT;
			cfg_q.padding          <= RST_PADDING;
		end else if (wr_en) begin
			case (reg_idx)
				REG_BONE_COUNT: cfg_q.bone_count       <= pwdata[CNT_W-1:0];
				REG_WEIGHT_THR: cfg_q.weight_threshold <= pwdata[WEIGHT_W-1:0];
				REG_MIN_EXTENT: cfg_q.min_extent       <= pwdata[EXT_W-1:0];
				REG_PADDING:    cfg_q.padding          <= pwdata[EXT_W-1:0];
				default: ;
			endcase
		end
	end

	// Read-back mux.
	always_comb begin
		case (reg_idx)
			REG_BONE_COUNT: prdata = PDATA_W'(cfg_q.bone_count);
			REG_WEIGHT_THR: prdata = PDATA_W'(cfg_q.weight_threshold);
			REG_MIN_EXTENT: prdata = PDATA_W'(cfg_q.min_extent);
			REG_PADDING:    prdata = PDATA_W'(cfg_q.padding);
			default:        prdata = '0;
		endcase
	end

endmodule

// ----- rtl/sbb_dp.sv -----
module sbb_dp import sbb_pkg::*; #(
	parameter int MAX_BONES  = DEF_MAX_BONES,
	parameter int INFLUENCES = DEF_INFLUENCES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  sbb_cfg_t    cfg,
	input  sbb_cmd_t    cmd,
	output sbb_status_t status,
	sbb_vtx_if.sink     vtx,
	sbb_box_if.source   box
);

	localparam int BIW = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;

	// Latched vertex item.
	pos_t                        pos_x_q, pos_y_q, pos_z_q;
	logic signed [BONE_ID_W-1:0] id_q [NUM_INFL];
	logic [WEIGHT_W-1:0]         wt_q [NUM_INFL];

	logic [INFL_W-1:0]   infl_q;
	logic [BIW-1:0]      bone_q;
	logic [MAX_BONES-1:0] touched_q;

	sbb_box_t mem_q [MAX_BONES];
	sbb_box_t rd_q;
	sbb_box_t merged;

	sbb_res_t pend_q, out_q, new_res, fin_res;
	logic     pend_valid_q, out_valid_q;

	logic signed [BONE_ID_W-1:0] cur_id;
	logic [WEIGHT_W-1:0]         cur_wt;
	logic [CNT_W-1:0]            limit;
	logic [BIW-1:0]              vtx_addr, mem_addr;
	logic                        infl_hit, out_free;
	logic signed [POS_W:0]       ext_x, ext_y, ext_z, ext_lim, pad_ext;

	assign vtx.ready = cmd.in_ready;

	// Item register; flush items leave it unused.
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			pos_x_q  <= vtx.pos_x;
			pos_y_q  <= vtx.pos_y;
			pos_z_q  <= vtx.pos_z;
			id_q[0]  <= vtx.bone_a;
			id_q[1]  <= vtx.bone_b;
			id_q[2]  <= vtx.bone_c;
			id_q[3]  <= vtx.bone_d;
			wt_q[0]  <= vtx.weight_a;
			wt_q[1]  <= vtx.weight_b;
			wt_q[2]  <= vtx.weight_c;
			wt_q[3]  <= vtx.weight_d;
		end
	end

	// Influence and bone counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			infl_q <= '0;
			bone_q <= '0;
		end else begin
			if (cmd.infl_clr) begin
				infl_q <= '0;
			end else if (cmd.infl_inc) begin
				infl_q <= infl_q + 1'b1;
			end
			if (cmd.bone_clr) begin
				bone_q <= '0;
			end else if (cmd.bone_inc) begin
				bone_q <= bone_q + 1'b1;
			end
		end
	end

	// Qualify the current influence against bone count and threshold.
	assign cur_id   = id_q[infl_q];
	assign cur_wt   = wt_q[infl_q];
	assign limit    = (cfg.bone_count > CNT_W'(MAX_BONES)) ? CNT_W'(MAX_BONES) : cfg.bone_count;
	assign infl_hit = !cur_id[BONE_ID_W-1]
		&& (cur_id[BONE_ID_W-2:0] < {1'b0, limit})
		&& (cur_wt >= cfg.weight_threshold);
	assign vtx_addr = cur_id[BIW-1:0];
	assign mem_addr = cmd.rd_bone ? bone_q : vtx_addr;

	// Widen the stored box; the first hit loads the position itself.
	always_comb begin
		if (!touched_q[vtx_addr]) begin
			merged.lo_x = pos_x_q;
			merged.lo_y = pos_y_q;
			merged.lo_z = pos_z_q;
			merged.hi_x = pos_x_q;
			merged.hi_y = pos_y_q;
			merged.hi_z = pos_z_q;
		end else begin
			merged.lo_x = (pos_x_q < rd_q.lo_x) ? pos_x_q : rd_q.lo_x;
			merged.lo_y = (pos_y_q < rd_q.lo_y) ? pos_y_q : rd_q.lo_y;
			merged.lo_z = (pos_z_q < rd_q.lo_z) ? pos_z_q : rd_q.lo_z;
			merged.hi_x = (pos_x_q > rd_q.hi_x) ? pos_x_q : rd_q.hi_x;
			merged.hi_y = (pos_y_q > rd_q.hi_y) ? pos_y_q : rd_q.hi_y;
			merged.hi_z = (pos_z_q > rd_q.hi_z) ? pos_z_q : rd_q.hi_z;
		end
	end

	// Bone box memory: one port, registered read data.
	always_ff @(posedge clk) begin
		if (cmd.wr_vtx) begin
			mem_q[vtx_addr] <= merged;
		end
		if (cmd.rd_vtx || cmd.rd_bone) begin
			rd_q <= mem_q[mem_addr];
		end
	end

	// Touched flags: set on write, all cleared at the end of a flush.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			touched_q <= '0;
		end else if (cmd.finish) begin
			touched_q <= '0;
		end else if (cmd.wr_vtx) begin
			touched_q[vtx_addr] <= 1'b1;
		end
	end

	// Extent check and padded box of the bone just read.
	assign ext_x   = {rd_q.hi_x[POS_W-1], rd_q.hi_x} - {rd_q.lo_x[POS_W-1], rd_q.lo_x};
	assign ext_y   = {rd_q.hi_y[POS_W-1], rd_q.hi_y} - {rd_q.lo_y[POS_W-1], rd_q.lo_y};
	assign ext_z   = {rd_q.hi_z[POS_W-1], rd_q.hi_z} - {rd_q.lo_z[POS_W-1], rd_q.lo_z};
	assign ext_lim = {2'b00, cfg.min_extent};
	assign pad_ext = {2'b00, cfg.padding};

	always_comb begin
		new_res.box_valid  = 1'b1;
		new_res.bone_index = BONE_IDX_W'(bone_q);
		new_res.min_x      = sat25({rd_q.lo_x[POS_W-1], rd_q.lo_x} - pad_ext);
		new_res.min_y      = sat25({rd_q.lo_y[POS_W-1], rd_q.lo_y} - pad_ext);
		new_res.min_z      = sat25({rd_q.lo_z[POS_W-1], rd_q.lo_z} - pad_ext);
		new_res.max_x      = sat25({rd_q.hi_x[POS_W-1], rd_q.hi_x} + pad_ext);
		new_res.max_y      = sat25({rd_q.hi_y[POS_W-1], rd_q.hi_y} + pad_ext);
		new_res.max_z      = sat25({rd_q.hi_z[POS_W-1], rd_q.hi_z} + pad_ext);
		new_res.last       = 1'b0;
	end

	// Closing result of a flush: the held box, or an empty one, marked last.
	always_comb begin
		if (pend_valid_q) begin
			fin_res = pend_q;
		end else begin
			fin_res = '0;
		end
		fin_res.last = 1'b1;
	end

	assign out_free = !out_valid_q || box.ready;

	// Pending result: held back until it is known whether it is the last one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (cmd.take_box) begin
			pend_valid_q <= 1'b1;
		end else if (cmd.finish) begin
			pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_box) begin
			pend_q <= new_res;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((cmd.take_box && pend_valid_q) || cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (box.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_box && pend_valid_q) begin
			out_q <= pend_q;
		end else if (cmd.finish) begin
			out_q <= fin_res;
		end
	end

	assign box.valid      = out_valid_q;
	assign box.box_valid  = out_q.box_valid;
	assign box.bone_index = out_q.bone_index;
	assign box.min_x      = out_q.min_x;
	assign box.min_y      = out_q.min_y;
	assign box.min_z      = out_q.min_z;
	assign box.max_x      = out_q.max_x;
	assign box.max_y      = out_q.max_y;
	assign box.max_z      = out_q.max_z;
	assign box.last       = out_q.last;

	// Status to the controller.
	always_comb begin
		status.in_valid     = vtx.valid;
		status.in_flush     = vtx.operation;
		status.infl_hit     = infl_hit;
		status.infl_last    = (infl_q == INFL_W'(INFLUENCES - 1));
		status.bone_touched = touched_q[bone_q];
		status.bone_last    = (bone_q == BIW'(MAX_BONES - 1));
		status.kept         = !((ext_x <= ext_lim) && (ext_y <= ext_lim) && (ext_z <= ext_lim));
		status.pend_valid   = pend_valid_q;
		status.out_free     = out_free;
	end

endmodule

// ----- rtl/sbb_ctrl.sv -----
module sbb_ctrl import sbb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  sbb_status_t status,
	output sbb_cmd_t    cmd
);

	sbb_state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.in_ready = 1'b1;
				if (status.in_valid) begin
					cmd.load_item = 1'b1;
					cmd.infl_clr  = 1'b1;
					cmd.bone_clr  = 1'b1;
					state_d       = status.in_flush ? ST_F_RD : ST_V_RD;
				end
			end
			ST_V_RD: begin
				if (status.infl_hit) begin
					cmd.rd_vtx = 1'b1;
					state_d    = ST_V_WR;
				end else if (status.infl_last) begin
					state_d = ST_IDLE;
				end else begin
					cmd.infl_inc = 1'b1;
				end
			end
			ST_V_WR: begin
				cmd.wr_vtx = 1'b1;
				if (status.infl_last) begin
					state_d = ST_IDLE;
				end else begin
					cmd.infl_inc = 1'b1;
					state_d      = ST_V_RD;
				end
			end
			ST_F_RD: begin
				if (status.bone_touched) begin
					cmd.rd_bone = 1'b1;
					state_d     = ST_F_EVAL;
				end else if (status.bone_last) begin
					state_d = ST_F_DONE;
				end else begin
					cmd.bone_inc = 1'b1;
				end
			end
			ST_F_EVAL: begin
				// A kept box pushes the pending one out; wait for a free slot.
				if (!(status.kept && status.pend_valid && !status.out_free)) begin
					cmd.take_box = status.kept;
					if (status.bone_last) begin
						state_d = ST_F_DONE;
					end else begin
						cmd.bone_inc = 1'b1;
						state_d      = ST_F_RD;
					end
				end
			end
			ST_F_DONE: begin
				if (status.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/skinned_bone_bounding_boxes.sv -----
// Per-bone axis-aligned bounding boxes of skinned vertices.
// The vtx channel takes items: operation 0 is a vertex with a Q11.12
// position and four bone/weight pairs, operation 1 is a flush. The box
// channel returns results; a flush yields one result per kept bone in bone
// order, the final one marked last, or a single result with box_valid low
// when no box is kept. The APB port sets bone count, weight threshold,
// minimum extent and padding; write it only while the block is idle.
// A vertex is taken in an accept state; each qualifying influence then
// passes through ST_V_RD and ST_V_WR, a read-modify-write of the
// single-port bone memory, and each skipped one through ST_V_RD alone.
// A flush is taken in the accept state, visits ST_F_RD for every bone and
// ST_F_EVAL for each touched bone and ends in a closing ST_F_DONE state;
// one item is in work at a time. Reset loads register defaults and clears
// every touched flag; the box memory itself needs no clearing. A stalled
// box receiver holds the output register and, when a further box is
// ready, pauses the bone walk until the slot frees.
module skinned_bone_bounding_boxes import sbb_pkg::*; #(
	parameter int MAX_BONES  = DEF_MAX_BONES,
	parameter int INFLUENCES = DEF_INFLUENCES
) (
	input  logic               clk,
	input  logic               arst_n,
	sbb_vtx_if.sink            vtx,
	sbb_box_if.source          box,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	sbb_cfg_t    cfg;
	sbb_cmd_t    cmd;
	sbb_status_t status;

	// Configuration registers.
	sbb_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Sequencer.
	sbb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.cmd    (cmd)
	);

	// Bone store, box math and output register.
	sbb_dp #(
		.MAX_BONES  (MAX_BONES),
		.INFLUENCES (INFLUENCES)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cmd    (cmd),
		.status (status),
		.vtx    (vtx),
		.box    (box)
	);

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
	import sbb_pkg::*;

	localparam int BONES = DEF_MAX_BONES;
	localparam logic OP_VERTEX = 1'b0;
	localparam logic OP_FLUSH = 1'b1;
	// Settling time for wait_until_idle, long enough for a flush to walk every bone.
	localparam int SETTLE_CYCLES = 2 * BONES + 16;
	// About 150 requests, a few dozen flushes of up to 64 boxes each, and stalls on both sides.
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int PRINT_CAP = 60;

	// One request on the vertex channel.
	typedef struct packed {
		logic                               op;
		pos_t                               pos_x;
		pos_t                               pos_y;
		pos_t                               pos_z;
		logic [NUM_INFL-1:0][BONE_ID_W-1:0] bone;
		logic [NUM_INFL-1:0][WEIGHT_W-1:0]  weight;
	} vertex_req_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	sbb_vtx_if vtx_ch ();
	sbb_box_if box_ch ();

	skinned_bone_bounding_boxes uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.vtx     (vtx_ch),
		.box     (box_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Predicted register values and per-bone boxes.
	logic [CNT_W-1:0]    cfg_bone_count;
	logic [WEIGHT_W-1:0] cfg_weight_threshold;
	logic [EXT_W-1:0]    cfg_min_extent;
	logic [EXT_W-1:0]    cfg_padding;
	sbb_box_t bone_box [BONES];
	bit       bone_touched [BONES];

	// Boxes that the block still owes, oldest first.
	sbb_res_t pending_boxes [$];

	int error_count = 0;
	int send_idle = 0;
	int recv_idle = 0;
	int unsigned cycle_count = 0;

	always #5 clk = ~clk;

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		// A badly broken block would flood the log, so only the first lines are printed.
		if (error_count < PRINT_CAP) begin
			$display("%0t: mismatch: %s", $realtime, what);
		end
		error_count++;
	endtask

	function automatic pos_t clamp_q(input int v);
		pos_t r;
		if (v < int'(Q_MIN)) begin
			r = Q_MIN;
		end else if (v > int'(Q_MAX)) begin
			r = Q_MAX;
		end else begin
			r = pos_t'(v);
		end
		return r;
	endfunction

	// Widens the stored box of one bone by a vertex position.
	task automatic widen_bone(input int b, input pos_t x, input pos_t y, input pos_t z);
		if (!bone_touched[b]) begin
			bone_box[b] = {x, y, z, x, y, z};
			bone_touched[b] = 1'b1;
		end else begin
			if ($signed(x) < $signed(bone_box[b].lo_x)) bone_box[b].lo_x = x;
			if ($signed(x) > $signed(bone_box[b].hi_x)) bone_box[b].hi_x = x;
			if ($signed(y) < $signed(bone_box[b].lo_y)) bone_box[b].lo_y = y;
			if ($signed(y) > $signed(bone_box[b].hi_y)) bone_box[b].hi_y = y;
			if ($signed(z) < $signed(bone_box[b].lo_z)) bone_box[b].lo_z = z;
			if ($signed(z) > $signed(bone_box[b].hi_z)) bone_box[b].hi_z = z;
		end
	endtask

	// Applies one accepted request and queues the boxes that it yields.
	task automatic predict_boxes(input vertex_req_t rq);
		int bone_limit;
		int id;
		int pad;
		int ex, ey, ez;
		bit have;
		sbb_res_t held;
		sbb_res_t r;
		if (rq.op == OP_VERTEX) begin
			bone_limit = (cfg_bone_count > BONES) ? BONES : int'(cfg_bone_count);
			for (int i = 0; i < NUM_INFL; i++) begin
				id = $signed(rq.bone[i]);
				if (id >= 0 && id < bone_limit && rq.weight[i] >= cfg_weight_threshold) begin
					widen_bone(id, rq.pos_x, rq.pos_y, rq.pos_z);
				end
			end
		end else begin
			pad = int'(cfg_padding);
			have = 1'b0;
			held = '0;
			// The walk covers all entries, whatever the bone count is now.
			for (int b = 0; b < BONES; b++) begin
				if (bone_touched[b]) begin
					ex = $signed(bone_box[b].hi_x) - $signed(bone_box[b].lo_x);
					ey = $signed(bone_box[b].hi_y) - $signed(bone_box[b].lo_y);
					ez = $signed(bone_box[b].hi_z) - $signed(bone_box[b].lo_z);
					if (ex > int'(cfg_min_extent) || ey > int'(cfg_min_extent) ||
							ez > int'(cfg_min_extent)) begin
						r.box_valid = 1'b1;
						r.bone_index = BONE_IDX_W'(b);
						r.min_x = clamp_q($signed(bone_box[b].lo_x) - pad);
						r.min_y = clamp_q($signed(bone_box[b].lo_y) - pad);
						r.min_z = clamp_q($signed(bone_box[b].lo_z) - pad);
						r.max_x = clamp_q($signed(bone_box[b].hi_x) + pad);
						r.max_y = clamp_q($signed(bone_box[b].hi_y) + pad);
						r.max_z = clamp_q($signed(bone_box[b].hi_z) + pad);
						r.last = 1'b0;
						if (have) pending_boxes = {pending_boxes, held};
						held = r;
						have = 1'b1;
					end
				end
				bone_touched[b] = 1'b0;
			end
			// Without any kept box the flush still answers with one empty result.
			if (!have) begin
				held = '0;
			end
			held.last = 1'b1;
			pending_boxes = {pending_boxes, held};
		end
	endtask

	task automatic check_field(input string name, input logic [POS_W-1:0] got,
			input logic [POS_W-1:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s is %h, expected %h", name, got, want));
		end
	endtask

	task automatic check_box();
		sbb_res_t want;
		if (pending_boxes.size() == 0) begin
			report_mismatch($sformatf("box for bone %0d arrived with nothing pending",
				box_ch.bone_index));
		end else begin
			want = pending_boxes.pop_front();
			check_field("box_valid", box_ch.box_valid, want.box_valid);
			check_field("bone_index", box_ch.bone_index, want.bone_index);
			check_field("min_x", box_ch.min_x, want.min_x);
			check_field("min_y", box_ch.min_y, want.min_y);
			check_field("min_z", box_ch.min_z, want.min_z);
			check_field("max_x", box_ch.max_x, want.max_x);
			check_field("max_y", box_ch.max_y, want.max_y);
			check_field("max_z", box_ch.max_z, want.max_z);
			check_field("last", box_ch.last, want.last);
		end
	endtask

	// Box receiver: checks each accepted box and stalls at random.
	always @(posedge clk) begin
		if (arst_n && box_ch.valid && box_ch.ready) begin
			check_box();
		end
		box_ch.ready <= arst_n && ($urandom_range(0, 99) >= recv_idle);
	end

	// Sends one request and updates the prediction once it is accepted.
	task automatic send_request(input vertex_req_t rq);
		while ($urandom_range(0, 99) < send_idle) begin
			vtx_ch.valid <= 1'b0;
			@(posedge clk);
		end
		vtx_ch.valid <= 1'b1;
		vtx_ch.operation <= rq.op;
		vtx_ch.pos_x <= rq.pos_x;
		vtx_ch.pos_y <= rq.pos_y;
		vtx_ch.pos_z <= rq.pos_z;
		vtx_ch.bone_a <= rq.bone[0];
		vtx_ch.bone_b <= rq.bone[1];
		vtx_ch.bone_c <= rq.bone[2];
		vtx_ch.bone_d <= rq.bone[3];
		vtx_ch.weight_a <= rq.weight[0];
		vtx_ch.weight_b <= rq.weight[1];
		vtx_ch.weight_c <= rq.weight[2];
		vtx_ch.weight_d <= rq.weight[3];
		@(posedge clk);
		while (!vtx_ch.ready) @(posedge clk);
		predict_boxes(rq);
	endtask

	// Waits until every box has arrived and the block has had time to finish any vertex.
	task automatic wait_until_idle();
		vtx_ch.valid <= 1'b0;
		while (pending_boxes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One register write: a setup phase, then an access phase.
	task automatic write_register(input sbb_reg_t idx, input logic [PDATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		case (idx)
			REG_BONE_COUNT: cfg_bone_count = value[CNT_W-1:0];
			REG_WEIGHT_THR: cfg_weight_threshold = value[WEIGHT_W-1:0];
			REG_MIN_EXTENT: cfg_min_extent = value[EXT_W-1:0];
			REG_PADDING:    cfg_padding = value[EXT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input int count, input int threshold, input int extent,
			input int pad);
		wait_until_idle();
		write_register(REG_BONE_COUNT, PDATA_W'(count));
		write_register(REG_WEIGHT_THR, PDATA_W'(threshold));
		write_register(REG_MIN_EXTENT, PDATA_W'(extent));
		write_register(REG_PADDING, PDATA_W'(pad));
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic vertex_req_t make_vertex(input int x, input int y, input int z,
			input int ba, input int bb, input int bc, input int bd,
			input int wa, input int wb, input int wc, input int wd);
		vertex_req_t r;
		r.op = OP_VERTEX;
		r.pos_x = pos_t'(x);
		r.pos_y = pos_t'(y);
		r.pos_z = pos_t'(z);
		r.bone[0] = BONE_ID_W'(ba);
		r.bone[1] = BONE_ID_W'(bb);
		r.bone[2] = BONE_ID_W'(bc);
		r.bone[3] = BONE_ID_W'(bd);
		r.weight[0] = WEIGHT_W'(wa);
		r.weight[1] = WEIGHT_W'(wb);
		r.weight[2] = WEIGHT_W'(wc);
		r.weight[3] = WEIGHT_W'(wd);
		return r;
	endfunction

	// A request with every field random, the operation included.
	function automatic vertex_req_t random_request();
		vertex_req_t r;
		r.op = 1'($urandom());
		r.pos_x = pos_t'($urandom());
		r.pos_y = pos_t'($urandom());
		r.pos_z = pos_t'($urandom());
		for (int i = 0; i < NUM_INFL; i++) begin
			r.bone[i] = BONE_ID_W'($urandom());
			r.weight[i] = WEIGHT_W'($urandom());
		end
		return r;
	endfunction

	function automatic vertex_req_t flush_request();
		vertex_req_t r;
		r = random_request();
		r.op = OP_FLUSH;
		return r;
	endfunction

	// Default registers: empty flush, saturation at both ends, threshold edge, ignored ids.
	task automatic test_defaults();
		send_request(flush_request());
		send_request(make_vertex(int'(Q_MAX), int'(Q_MAX), int'(Q_MAX),
			0, -1, -256, 255, 255, 255, 255, 255));
		send_request(make_vertex(int'(Q_MIN), int'(Q_MIN), int'(Q_MIN),
			0, 64, 1, -1, 102, 255, 101, 0));
		// The same bone twice in one vertex, and boxes right at the extent limit.
		send_request(make_vertex(1, 2, 3, 2, 3, 4, 2, 200, 200, 200, 200));
		send_request(make_vertex(5, 2, 3, 3, -1, -1, -1, 255, 0, 0, 0));
		send_request(make_vertex(1, 2, 8, 4, -1, -1, -1, 255, 0, 0, 0));
		send_request(flush_request());
	endtask

	// Registers at their extremes, including a bone count beyond the number of bones.
	task automatic test_register_extremes();
		set_config(127, 0, 0, 8388607);
		send_request(make_vertex(int'(Q_MIN), 0, int'(Q_MAX), 63, 5, -1, -1, 0, 0, 0, 0));
		send_request(make_vertex(0, 0, 0, 63, -1, -1, -1, 0, 0, 0, 0));
		send_request(flush_request());
		// With no bones in use every vertex is ignored.
		set_config(0, 255, 8388607, 0);
		send_request(make_vertex(0, 0, 0, 0, 1, 2, 3, 255, 255, 255, 255));
		send_request(flush_request());
		set_config(1, 255, 8388607, 0);
		send_request(make_vertex(int'(Q_MIN), int'(Q_MIN), int'(Q_MIN),
			0, 1, -1, -1, 255, 255, 0, 0));
		send_request(make_vertex(int'(Q_MAX), int'(Q_MAX), int'(Q_MAX),
			0, -1, -1, -1, 254, 0, 0, 0));
		send_request(make_vertex(int'(Q_MAX), 0, 0, 0, 1, 63, -1, 255, 255, 255, 0));
		send_request(flush_request());
	endtask

	// Bones gathered under a large count are still emitted after the count shrinks.
	task automatic test_bone_count_shrink();
		set_config(64, 102, 4, 41);
		send_request(make_vertex(100, 200, 300, 50, 63, 0, -1, 255, 255, 255, 0));
		send_request(make_vertex(-100, -200, -300, 50, 63, 0, -1, 255, 255, 255, 0));
		set_config(10, 102, 4, 41);
		send_request(make_vertex(1000, 0, 0, 50, 9, 0, 10, 255, 255, 255, 255));
		send_request(flush_request());
	endtask

	task automatic randomize_config();
		int count, threshold, extent, pad;
		case ($urandom_range(0, 4))
			0: count = 64;
			1: count = $urandom_range(1, 8);
			2: count = $urandom_range(65, 127);
			3: count = 0;
			default: count = $urandom_range(1, 64);
		endcase
		case ($urandom_range(0, 3))
			0: threshold = 0;
			1: threshold = 255;
			default: threshold = $urandom_range(0, 255);
		endcase
		case ($urandom_range(0, 4))
			0: extent = 0;
			1: extent = 8388607;
			2: extent = $urandom_range(0, 8388607);
			default: extent = $urandom_range(0, 4096);
		endcase
		case ($urandom_range(0, 4))
			0: pad = 0;
			1: pad = 8388607;
			2: pad = $urandom_range(0, 8388607);
			default: pad = $urandom_range(0, 4096);
		endcase
		set_config(count, threshold, extent, pad);
	endtask

	// Scenes of clustered vertices on a few bones closed by a flush, with some noise mixed in.
	task automatic test_random_traffic(input int goal, input int s_idle, input int r_idle);
		int sent;
		int n_vtx;
		int bone_limit;
		int spread;
		int off;
		int sel;
		int id;
		int center [3];
		int scene_bones [4];
		vertex_req_t rq;
		send_idle = s_idle;
		recv_idle = r_idle;
		sent = 0;
		while (sent < goal) begin
			if ($urandom_range(0, 2) == 0) randomize_config();
			bone_limit = (cfg_bone_count > BONES) ? BONES : int'(cfg_bone_count);
			spread = $urandom_range(0, 23);
			for (int j = 0; j < 3; j++) center[j] = int'(pos_t'($urandom()));
			for (int j = 0; j < 4; j++) begin
				scene_bones[j] = (bone_limit > 0) ? $urandom_range(0, bone_limit - 1) :
					$urandom_range(0, BONES - 1);
			end
			n_vtx = $urandom_range(1, 12);
			for (int k = 0; k <= n_vtx; k++) begin
				if ($urandom_range(0, 99) < 12) begin
					rq = random_request();
				end else if (k == n_vtx) begin
					rq = flush_request();
				end else begin
					rq = random_request();
					rq.op = OP_VERTEX;
					off = $urandom_range(0, 2 * (1 << spread));
					rq.pos_x = pos_t'(center[0] + off - (1 << spread));
					off = $urandom_range(0, 2 * (1 << spread));
					rq.pos_y = pos_t'(center[1] + off - (1 << spread));
					off = $urandom_range(0, 2 * (1 << spread));
					rq.pos_z = pos_t'(center[2] + off - (1 << spread));
					for (int i = 0; i < NUM_INFL; i++) begin
						sel = $urandom_range(0, 99);
						if (sel < 75) begin
							id = scene_bones[$urandom_range(0, 3)];
						end else if (sel < 85) begin
							id = -int'($urandom_range(1, 256));
						end else begin
							id = $urandom_range(0, 255);
						end
						rq.bone[i] = BONE_ID_W'(id);
						if ($urandom_range(0, 1) == 1) begin
							rq.weight[i] = WEIGHT_W'($urandom_range(cfg_weight_threshold, 255));
						end
					end
				end
				send_request(rq);
				sent++;
			end
		end
		wait_until_idle();
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		box_ch.ready = 1'b0;
		vtx_ch.valid = 1'b0;
		vtx_ch.operation = OP_VERTEX;
		vtx_ch.pos_x = '0;
		vtx_ch.pos_y = '0;
		vtx_ch.pos_z = '0;
		vtx_ch.bone_a = '0;
		vtx_ch.bone_b = '0;
		vtx_ch.bone_c = '0;
		vtx_ch.bone_d = '0;
		vtx_ch.weight_a = '0;
		vtx_ch.weight_b = '0;
		vtx_ch.weight_c = '0;
		vtx_ch.weight_d = '0;
		cfg_bone_count = RST_BONE_COUNT;
		cfg_weight_threshold = RST_WEIGHT_THR;
		cfg_min_extent = RST_MIN_EXTENT;
		cfg_padding = RST_PADDING;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_defaults();
		test_register_extremes();
		test_bone_count_shrink();
		test_random_traffic(40, 31, 54);
		test_random_traffic(40, 54, 31);
		test_random_traffic(40, 0, 0);

		wait_until_idle();
		if (error_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/sbb_pkg.sv
rtl/sbb_vtx_if.sv
rtl/sbb_box_if.sv
rtl/sbb_cfg.sv
rtl/sbb_dp.sv
rtl/sbb_ctrl.sv
rtl/skinned_bone_bounding_boxes.sv
test/testbench.sv
